FILE: hw/rtl/chp_pkg.sv
// Shared package for the monotone-chain convex hull block.
// Holds default sizes, the controller state type and the cell chain operation codes.
// No dependencies.
package chp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // Operation applied to every cell of a chain in the same cycle
  typedef enum logic [2:0] {
    COP_HOLD,
    COP_PUSH,    // shift toward the tail, head takes din
    COP_POP,     // shift toward the head, tail goes empty
    COP_INSERT,  // sorted insert of din (x, then y)
    COP_CLEAR
  } cop_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ECHO,
    ST_DEDUP,
    ST_REFILL,
    ST_EMIT_S,
    ST_LOW,
    ST_LOW_CMP,
    ST_UP_DROP,
    ST_UP,
    ST_UP_CMP,
    ST_CLOSE,
    ST_REV,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/chp_if.sv
// Valid/ready channel interfaces for points in and hull vertices out.
// Depends on chp_pkg for default widths.
interface pt_if import chp_pkg::*; #(parameter int CW = COORD_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic                 last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface hull_if import chp_pkg::*; #(parameter int CW = COORD_BITS_DEF) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] hull_x;
  logic signed [CW-1:0] hull_y;
  logic                 hull_last;
  logic                 overflowed;

  modport source (output valid, hull_x, hull_y, hull_last, overflowed, input ready);
  modport sink   (input valid, hull_x, hull_y, hull_last, overflowed, output ready);
endinterface

FILE: hw/rtl/chp_cell.sv
// One cell of a point chain: holds one point and a valid bit.
// Depends on chp_pkg (cop_t).
module chp_cell import chp_pkg::*; #(
  parameter int CW = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cop_t                 op,
  input  logic signed [CW-1:0] ins_x,
  input  logic signed [CW-1:0] ins_y,
  input  logic signed [CW-1:0] lx,
  input  logic signed [CW-1:0] ly,
  input  logic                 lvalid,
  input  logic                 llt,
  input  logic signed [CW-1:0] rx,
  input  logic signed [CW-1:0] ry,
  input  logic                 rvalid,
  output logic signed [CW-1:0] x,
  output logic signed [CW-1:0] y,
  output logic                 valid,
  output logic                 lt
);

  // Inserted point goes ahead of this one (empty cell counts as +inf)
  assign lt = !valid || (ins_x < x) || ((ins_x == x) && (ins_y < y));

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        COP_PUSH:   valid <= lvalid;
        COP_POP:    valid <= rvalid;
        COP_INSERT: valid <= llt ? lvalid : (lt ? 1'b1 : valid);
        COP_CLEAR:  valid <= 1'b0;
        default:    valid <= valid;
      endcase
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    case (op)
      COP_PUSH: begin
        x <= lx;
        y <= ly;
      end
      COP_POP: begin
        x <= rx;
        y <= ry;
      end
      COP_INSERT: begin
        if (llt) begin
          x <= lx;
          y <= ly;
        end else if (lt) begin
          x <= ins_x;
          y <= ins_y;
        end
      end
      default: begin
        x <= x;
        y <= y;
      end
    endcase
  end

endmodule

FILE: hw/rtl/chp_chain.sv
// Row of chp_cell instances used as a stack or a sorted insertion list.
// Depends on chp_pkg and chp_cell. Exposes the two head cells.
module chp_chain import chp_pkg::*; #(
  parameter int CW    = COORD_BITS_DEF,
  parameter int DEPTH = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cop_t                 op,
  input  logic signed [CW-1:0] din_x,
  input  logic signed [CW-1:0] din_y,
  output logic signed [CW-1:0] h0_x,
  output logic signed [CW-1:0] h0_y,
  output logic                 h0_valid,
  output logic signed [CW-1:0] h1_x,
  output logic signed [CW-1:0] h1_y,
  output logic                 h1_valid
);

  logic signed [CW-1:0] cx [DEPTH];
  logic signed [CW-1:0] cy [DEPTH];
  logic                 cv [DEPTH];
  logic                 clt[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [CW-1:0] lx, ly, rx, ry;
    logic                 lv, llt, rv;

    // Neighbor hookup; head sees din, tail sees an empty cell
    if (i == 0) begin : g_head
      assign lx  = din_x;
      assign ly  = din_y;
      assign lv  = 1'b1;
      assign llt = 1'b0;
    end else begin : g_mid
      assign lx  = cx[i-1];
      assign ly  = cy[i-1];
      assign lv  = cv[i-1];
      assign llt = clt[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rx = '0;
      assign ry = '0;
      assign rv = 1'b0;
    end else begin : g_inner
      assign rx = cx[i+1];
      assign ry = cy[i+1];
      assign rv = cv[i+1];
    end

    chp_cell #(.CW(CW)) u_cell (
      .clk(clk), .rst(rst), .op(op),
      .ins_x(din_x), .ins_y(din_y),
      .lx(lx), .ly(ly), .lvalid(lv), .llt(llt),
      .rx(rx), .ry(ry), .rvalid(rv),
      .x(cx[i]), .y(cy[i]), .valid(cv[i]), .lt(clt[i])
    );
  end

  assign h0_x     = cx[0];
  assign h0_y     = cy[0];
  assign h0_valid = cv[0];
  assign h1_x     = cx[1];
  assign h1_y     = cy[1];
  assign h1_valid = cv[1];

endmodule

FILE: hw/rtl/convex_hull_2d_monotone_chain.sv
// Convex hull (monotone chain) over up to MAX_POINTS points. Loading takes a point whenever offered.
// After the last point: dedup and refill, then lower and upper passes that push each point,
// with a registered turn test first once the stack is deep enough, then reversal, then
// one vertex per cycle out while the output is not stalled. Small sets skip the passes.
// Sequential: the next set is taken once the last vertex is in the output register.
// Synchronous active-high reset empties all cell chains and clears count and overflow.
// Depends on chp_pkg, chp_if, chp_cell, chp_chain.
module convex_hull_2d_monotone_chain import chp_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic   clk,
  input logic   rst,
  pt_if.sink    pts,
  hull_if.source hull
);

  localparam int CW = COORD_BITS;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int TW = $clog2(MAX_POINTS + 2);
  localparam int PW = 2 * CW + 2;

  state_t state, state_next;

  // Chain ports
  cop_t s_op, r_op, h_op;
  logic signed [CW-1:0] s_dx, s_dy, r_dx, r_dy, h_dx, h_dy;
  logic signed [CW-1:0] s0x, s0y, s1x, s1y, r0x, r0y, r1x, r1y, h0x, h0y, h1x, h1y;
  logic s0v, s1v, r0v, r1v, h0v, h1v;

  // Control registers
  logic [NW-1:0] count;
  logic          ovf;
  logic [1:0]    mcnt;
  logic          eidx;
  logic [TW-1:0] top, lower;
  logic signed [CW-1:0] e0x, e0y, e1x, e1y;
  logic signed [PW-1:0] prod1, prod2;

  // Output register
  logic                 out_valid;
  logic signed [CW-1:0] out_x, out_y;
  logic                 out_last, out_ovf;

  // Strobes from the output decode
  logic acc, store_pt, ld, finish, push_m, top_inc, top_dec, mul_en, set_lower;
  logic signed [CW-1:0] ld_x, ld_y, p_x, p_y;
  logic ld_last;
  logic [NW:0] n_after;
  logic can_load, left;

  chp_chain #(.CW(CW), .DEPTH(MAX_POINTS)) u_sort (
    .clk(clk), .rst(rst), .op(s_op), .din_x(s_dx), .din_y(s_dy),
    .h0_x(s0x), .h0_y(s0y), .h0_valid(s0v), .h1_x(s1x), .h1_y(s1y), .h1_valid(s1v));

  chp_chain #(.CW(CW), .DEPTH(MAX_POINTS)) u_ret (
    .clk(clk), .rst(rst), .op(r_op), .din_x(r_dx), .din_y(r_dy),
    .h0_x(r0x), .h0_y(r0y), .h0_valid(r0v), .h1_x(r1x), .h1_y(r1y), .h1_valid(r1v));

  chp_chain #(.CW(CW), .DEPTH(MAX_POINTS + 1)) u_hull (
    .clk(clk), .rst(rst), .op(h_op), .din_x(h_dx), .din_y(h_dy),
    .h0_x(h0x), .h0_y(h0y), .h0_valid(h0v), .h1_x(h1x), .h1_y(h1y), .h1_valid(h1v));

  assign can_load = !out_valid || hull.ready;
  assign acc      = pts.valid && pts.ready;
  assign store_pt = acc && (count < NW'(MAX_POINTS));
  assign n_after  = {1'b0, count} + (NW+1)'(store_pt);
  assign left     = prod1 > prod2;
  // Candidate point: sorted list in the lower pass, return stack in the upper pass
  assign p_x = (state == ST_LOW || state == ST_LOW_CMP) ? s0x : r0x;
  assign p_y = (state == ST_LOW || state == ST_LOW_CMP) ? s0y : r0y;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:
        if (acc && pts.last_point) begin
          state_next = (n_after < (NW+1)'(3)) ? ST_ECHO : ST_DEDUP;
        end
      ST_ECHO:
        if (can_load && ({1'b0, eidx} + 2'd1 == count[1:0])) state_next = ST_LOAD;
      ST_DEDUP:  if (!s0v) state_next = ST_REFILL;
      ST_REFILL: if (!r0v) state_next = (mcnt < 2'd3) ? ST_EMIT_S : ST_LOW;
      ST_EMIT_S: if (can_load && !s1v) state_next = ST_LOAD;
      ST_LOW: begin
        if (!s0v) state_next = ST_UP_DROP;
        else if (top >= TW'(2)) state_next = ST_LOW_CMP;
      end
      ST_LOW_CMP: state_next = ST_LOW;
      ST_UP_DROP: state_next = ST_UP;
      ST_UP: begin
        if (!r0v) state_next = ST_CLOSE;
        else if ({1'b0, top} >= {1'b0, lower} + (TW+1)'(1)) state_next = ST_UP_CMP;
      end
      ST_UP_CMP: state_next = ST_UP;
      ST_CLOSE:  state_next = ST_REV;
      ST_REV:    if (!h0v) state_next = ST_OUT;
      ST_OUT:    if (can_load && !r1v) state_next = ST_LOAD;
      default:   state_next = ST_LOAD;
    endcase
  end

  // Chain operations and strobes
  always_comb begin
    s_op = COP_HOLD; r_op = COP_HOLD; h_op = COP_HOLD;
    s_dx = pts.point_x; s_dy = pts.point_y;
    r_dx = s0x; r_dy = s0y;
    h_dx = p_x; h_dy = p_y;
    pts.ready = 1'b0;
    ld = 1'b0; ld_x = r0x; ld_y = r0y; ld_last = 1'b0;
    finish = 1'b0; push_m = 1'b0; top_inc = 1'b0; top_dec = 1'b0;
    mul_en = 1'b0; set_lower = 1'b0;
    case (state)
      ST_LOAD: begin
        pts.ready = 1'b1;
        if (store_pt) s_op = COP_INSERT;
      end
      ST_ECHO: begin
        ld_x = eidx ? e1x : e0x;
        ld_y = eidx ? e1y : e0y;
        ld_last = ({1'b0, eidx} + 2'd1 == count[1:0]);
        ld = can_load;
        finish = can_load && ld_last;
        if (finish) s_op = COP_CLEAR;
      end
      ST_DEDUP: begin
        // Sorted list drains into the return stack, dropping exact repeats
        if (s0v) begin
          s_op = COP_POP;
          if (!r0v || s0x != r0x || s0y != r0y) begin
            r_op = COP_PUSH;
            push_m = 1'b1;
          end
        end
      end
      ST_REFILL: begin
        if (r0v) begin
          r_op = COP_POP;
          s_op = COP_PUSH;
          s_dx = r0x; s_dy = r0y;
        end
      end
      ST_EMIT_S: begin
        ld_x = s0x; ld_y = s0y; ld_last = !s1v;
        ld = can_load;
        if (can_load) s_op = COP_POP;
        finish = can_load && !s1v;
      end
      ST_LOW: begin
        if (!s0v) begin
          set_lower = 1'b1;
        end else if (top >= TW'(2)) begin
          mul_en = 1'b1;
        end else begin
          h_op = COP_PUSH; s_op = COP_POP; r_op = COP_PUSH; top_inc = 1'b1;
        end
      end
      ST_LOW_CMP: begin
        if (left) begin
          h_op = COP_PUSH; s_op = COP_POP; r_op = COP_PUSH; top_inc = 1'b1;
        end else begin
          h_op = COP_POP; top_dec = 1'b1;
        end
      end
      ST_UP_DROP: r_op = COP_POP;   // rightmost point is already on the hull
      ST_UP: begin
        if (r0v) begin
          if ({1'b0, top} >= {1'b0, lower} + (TW+1)'(1)) begin
            mul_en = 1'b1;
          end else begin
            h_op = COP_PUSH; r_op = COP_POP; top_inc = 1'b1;
          end
        end
      end
      ST_UP_CMP: begin
        if (left) begin
          h_op = COP_PUSH; r_op = COP_POP; top_inc = 1'b1;
        end else begin
          h_op = COP_POP; top_dec = 1'b1;
        end
      end
      ST_CLOSE: begin
        if (top > TW'(1)) begin
          h_op = COP_POP; top_dec = 1'b1;
        end
      end
      ST_REV: begin
        // Turn the hull stack over so vertices leave in counter-clockwise order
        if (h0v) begin
          h_op = COP_POP; r_op = COP_PUSH;
          r_dx = h0x; r_dy = h0y;
        end
      end
      ST_OUT: begin
        ld_x = r0x; ld_y = r0y; ld_last = !r1v;
        ld = can_load;
        if (can_load) r_op = COP_POP;
        finish = can_load && !r1v;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      mcnt  <= '0;
      eidx  <= 1'b0;
      top   <= '0;
      lower <= '0;
    end else begin
      state <= state_next;
      if (store_pt) count <= count + NW'(1);
      if (acc && !store_pt) ovf <= 1'b1;
      if (state == ST_LOAD) begin
        mcnt <= '0;
        eidx <= 1'b0;
        top  <= '0;
      end
      if (push_m && mcnt != 2'd3) mcnt <= mcnt + 2'd1;
      if (state == ST_ECHO && ld) eidx <= 1'b1;
      if (top_inc) top <= top + TW'(1);
      if (top_dec) top <= top - TW'(1);
      if (set_lower) lower <= top;
      if (finish) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Arrival-order copies of the first two points
  always_ff @(posedge clk) begin
    if (store_pt && count == NW'(0)) begin
      e0x <= pts.point_x;
      e0y <= pts.point_y;
    end
    if (store_pt && count == NW'(1)) begin
      e1x <= pts.point_x;
      e1y <= pts.point_y;
    end
  end

  // Cross product terms for the turn test, registered
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod1 <= PW'(($signed({h0x[CW-1], h0x}) - $signed({h1x[CW-1], h1x})) *
                   ($signed({p_y[CW-1], p_y}) - $signed({h0y[CW-1], h0y})));
      prod2 <= PW'(($signed({h0y[CW-1], h0y}) - $signed({h1y[CW-1], h1y})) *
                   ($signed({p_x[CW-1], p_x}) - $signed({h0x[CW-1], h0x})));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= 1'b1;
    end else if (hull.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_x    <= ld_x;
      out_y    <= ld_y;
      out_last <= ld_last;
      out_ovf  <= ovf;
    end
  end

  assign hull.valid      = out_valid;
  assign hull.hull_x     = out_x;
  assign hull.hull_y     = out_y;
  assign hull.hull_last  = out_last;
  assign hull.overflowed = out_ovf;

endmodule

FILE: hw/rtl/chp_checker.sv
// Port-level assertions for the convex hull block, bound to the top level.
// Depends on convex_hull_2d_monotone_chain ports only.
module chp_checker #(
  parameter int CW = 16
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          in_last,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_last,
  input logic [CW-1:0] out_x,
  input logic [CW-1:0] out_y
);

  // Stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("hull vertex changed while stalled");

  // Closing a set stops intake while the hull is worked out
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("point taken right after the final point");

  // Final vertex leaves nothing behind
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("vertex follows the final vertex at once");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind convex_hull_2d_monotone_chain chp_checker #(.CW(COORD_BITS)) u_chp_checker (
  .clk(clk), .rst(rst),
  .in_valid(pts.valid), .in_ready(pts.ready), .in_last(pts.last_point),
  .out_valid(hull.valid), .out_ready(hull.ready), .out_last(hull.hull_last),
  .out_x(hull.hull_x), .out_y(hull.hull_y)
);
